>>> design/hnc_pkg.sv
// Package for the Hamming nibble codec: field widths, operation and status
// codes, and the per-rate single-bit correction table.
// No dependencies.
`default_nettype none

package hnc_pkg;

   // Field widths
   localparam int unsigned OP_W     = 1;
   localparam int unsigned RATE_W   = 2;
   localparam int unsigned WORD_W   = 8;
   localparam int unsigned BITS_W   = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned NIBBLE_W = 4;
   localparam int unsigned SYN_W    = 4;
   localparam int unsigned POS_W    = 4;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [RATE_W-1:0]   rate_type;
   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [BITS_W-1:0]   bits_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SYN_W-1:0]    syn_type;
   typedef logic [POS_W-1:0]    pos_type;

   // Operation codes
   localparam op_type OP_ENCODE = 1'b0;
   localparam op_type OP_DECODE = 1'b1;

   // Code rates
   localparam rate_type RATE_4_5 = 2'd0;
   localparam rate_type RATE_4_6 = 2'd1;
   localparam rate_type RATE_4_7 = 2'd2;
   localparam rate_type RATE_4_8 = 2'd3;

   // Status codes
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_CORRECTED = 2'd1;
   localparam status_type STATUS_UNCORRECT = 2'd2;

   // Shortest codeword width; the width grows by one per rate step
   localparam bits_type MIN_CW_BITS = 4'd5;

   // Per rate and syndrome: zero means no correctable pattern,
   // otherwise the codeword bit position plus one
   localparam pos_type FLIP_TABLE [4][16] = '{
      '{4'd0, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd5, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd5, 4'd6, 4'd1, 4'd7, 4'd2, 4'd3, 4'd4,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
      '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd8, 4'd5, 4'd6, 4'd1, 4'd7, 4'd2, 4'd3, 4'd4}
   };

endpackage

`default_nettype wire

>>> design/hnc_if.sv
// Valid/ready channel interfaces for the Hamming nibble codec: request
// items (operation, rate, word) and response items. Depends on hnc_pkg.
`default_nettype none

interface hnc_req_if
   import hnc_pkg::*;
   ;
   logic     valid;
   logic     ready;
   op_type   operation;
   rate_type code_rate;
   word_type data_word;

   modport source (output valid, output operation, output code_rate,
                   output data_word, input ready);
   modport sink   (input valid, input operation, input code_rate,
                   input data_word, output ready);
endinterface

interface hnc_rsp_if
   import hnc_pkg::*;
   ;
   logic       valid;
   logic       ready;
   word_type   word_out;
   bits_type   codeword_bits;
   status_type status;

   modport source (output valid, output word_out, output codeword_bits,
                   output status, input ready);
   modport sink   (input valid, input word_out, input codeword_bits,
                   input status, output ready);
endinterface

`default_nettype wire

>>> design/hamming_nibble_codec_core.sv
// Hamming nibble codec core: encodes a nibble into a 5..8 bit codeword or
// decodes and corrects such a codeword.
// Usage:
//   req_chan (sink): one item per valid&ready edge carrying operation,
//     code_rate and data_word. Encode takes the nibble in data_word[3:0];
//     decode takes the received codeword, bits above its width ignored.
//   rsp_chan (source): one item per request, in order, carrying word_out,
//     codeword_bits (width on encode, 0 on decode) and status
//     (ok / corrected / uncorrectable; always ok on encode).
// Flow: an accepted item waits in the input register; its result is
//   computed from there and presented on rsp_chan from the result register.
// Throughput: one item per cycle while rsp_chan.ready is high; XOR logic and
//   a small constant table lie between the input and result registers.
// Reset (synchronous, active high) empties both registers; no state is kept
//   between items.
// Stall: while rsp_chan.ready is low the result holds; the input register
//   still takes one more item, after which req_chan.ready drops until the
//   result is taken.
// Depends on hnc_pkg and hnc_if.
`default_nettype none

module hamming_nibble_codec_core
   import hnc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   hnc_req_if.sink     req_chan,
   hnc_rsp_if.source   rsp_chan
);

   // Input register
   logic     in_valid_ff, in_valid_in;
   op_type   in_op_ff;
   rate_type in_rate_ff;
   word_type in_word_ff;

   // Result register
   logic       out_valid_ff, out_valid_in;
   word_type   out_word_ff, out_word_in;
   bits_type   out_bits_ff, out_bits_in;
   status_type out_status_ff, out_status_in;

   logic out_load;
   logic in_load;

   // Codec signals
   logic                d0, d1, d2, d3;
   logic                p0, p1, p2, p3;
   logic                rate_ge1, rate_ge2, rate_ge3;
   word_type            enc_word;
   word_type            cw_mask;
   word_type            cw;
   word_type            fixed_cw;
   logic                s0, s1, s2, s3;
   syn_type             syn;
   pos_type             pos;
   logic [2:0]          flip_idx;

   // Advance the result register when empty or being taken
   assign out_load = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || out_load;
   assign in_load = req_chan.valid && req_chan.ready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_chan.ready);

   // Rate thresholds
   assign rate_ge1 = (in_rate_ff != RATE_4_5);
   assign rate_ge2 = (in_rate_ff == RATE_4_7) || (in_rate_ff == RATE_4_8);
   assign rate_ge3 = (in_rate_ff == RATE_4_8);

   // Encode: parity bits over the nibble, punctured by rate
   always_comb begin
      d0 = in_word_ff[0];
      d1 = in_word_ff[1];
      d2 = in_word_ff[2];
      d3 = in_word_ff[3];
      p1 = d0 ^ d1 ^ d3;
      p2 = d0 ^ d2 ^ d3;
      p3 = d1 ^ d2 ^ d3;
      p0 = d0 ^ d1 ^ d2 ^ d3 ^ p1 ^ p2 ^ p3;
      enc_word = {p0 & rate_ge3, p3 & rate_ge2, p2 & rate_ge1, p1,
                  in_word_ff[3:0]};
   end

   // Decode: mask to width, form syndrome, look up the bit to flip
   always_comb begin
      cw_mask  = {rate_ge3, rate_ge2, rate_ge1, 5'h1F};
      cw       = in_word_ff & cw_mask;
      s1       = cw[0] ^ cw[1] ^ cw[3] ^ cw[4];
      s2       = rate_ge1 & (cw[0] ^ cw[2] ^ cw[3] ^ cw[5]);
      s3       = rate_ge2 & (cw[1] ^ cw[2] ^ cw[3] ^ cw[6]);
      s0       = rate_ge3 & (^cw);
      syn      = {s0, s3, s2, s1};
      pos      = FLIP_TABLE[in_rate_ff][syn];
      flip_idx = 3'(pos - 4'd1);
      fixed_cw = cw ^ (word_type'(1) << flip_idx);
   end

   // Select the result of the item
   always_comb begin
      out_word_in   = enc_word;
      out_bits_in   = MIN_CW_BITS + bits_type'(in_rate_ff);
      out_status_in = STATUS_OK;
      if (in_op_ff == OP_DECODE) begin
         out_bits_in = '0;
         if (syn == '0) begin
            out_word_in   = {4'h0, cw[3:0]};
            out_status_in = STATUS_OK;
         end else if (pos == '0) begin
            out_word_in   = '0;
            out_status_in = STATUS_UNCORRECT;
         end else begin
            out_word_in   = {4'h0, fixed_cw[3:0]};
            out_status_in = STATUS_CORRECTED;
         end
      end
   end

   // Hold or advance the control bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture request payload
   always_ff @(posedge clock) begin
      if (in_load) begin
         in_op_ff   <= req_chan.operation;
         in_rate_ff <= req_chan.code_rate;
         in_word_ff <= req_chan.data_word;
      end
   end

   // Capture result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_word_ff   <= out_word_in;
         out_bits_ff   <= out_bits_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.word_out      = out_word_ff;
   assign rsp_chan.codeword_bits = out_bits_ff;
   assign rsp_chan.status        = out_status_ff;

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for hamming_nibble_codec_core: a directed table, then random encode and
// decode items with bursty sending and a stalling receiver, checked against a predictor.
// Depends on hnc_pkg, hnc_if and the codec core.
`default_nettype none

module tb
   import hnc_pkg::*;
   ;

   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 1850;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 400000;

   typedef struct packed {
      word_type   word_out;
      bits_type   codeword_bits;
      status_type status;
   } codec_result_type;

   // One row of the directed table; known is set where the result is typed in
   typedef struct packed {
      op_type     op;
      rate_type   rate;
      word_type   word;
      logic       known;
      word_type   exp_word;
      bits_type   exp_bits;
      status_type exp_status;
   } directed_row_type;

   typedef enum {RX_OPEN, RX_COIN, RX_CHOKED, RX_PERIODIC} rx_mode_type;

   logic clock;
   logic reset;

   hnc_req_if req_bus ();
   hnc_rsp_if rsp_bus ();

   hamming_nibble_codec_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   codec_result_type pending_results [$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   int               burst_left     = 0;
   rx_mode_type      rx_mode        = RX_OPEN;
   int               rx_left        = 0;
   directed_row_type directed_rows [18];

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Build the codeword for a nibble, truncated to the width of the rate
   function automatic word_type hamming_encode(logic [3:0] nib, rate_type rt);
      logic     p1, p2, p3, p0;
      word_type cw;
      p1 = nib[0] ^ nib[1] ^ nib[3];
      p2 = nib[0] ^ nib[2] ^ nib[3];
      p3 = nib[1] ^ nib[2] ^ nib[3];
      p0 = ^{nib, p1, p2, p3};
      cw = {p0, p3, p2, p1, nib};
      case (rt)
         RATE_4_5: cw[7:5] = 3'b000;
         RATE_4_6: cw[7:6] = 2'b00;
         RATE_4_7: cw[7]   = 1'b0;
         default: ;
      endcase
      return cw;
   endfunction

   // Expected result of one item: encode, or syndrome decode with single-bit repair
   function automatic codec_result_type hamming_result(op_type op, rate_type rt, word_type w);
      codec_result_type r;
      bits_type         width;
      int unsigned      mask;
      word_type         cw;
      syn_type          syn;
      logic             fixable;
      int               flip_pos;
      width = MIN_CW_BITS + bits_type'(rt);
      if (op == OP_ENCODE) begin
         r.word_out      = hamming_encode(w[3:0], rt);
         r.codeword_bits = width;
         r.status        = STATUS_OK;
         return r;
      end
      mask = (1 << width) - 1;
      cw   = w & mask[7:0];
      syn[0] = cw[0] ^ cw[1] ^ cw[3] ^ cw[4];
      syn[1] = (rt >= RATE_4_6) ? (cw[0] ^ cw[2] ^ cw[3] ^ cw[5]) : 1'b0;
      syn[2] = (rt >= RATE_4_7) ? (cw[1] ^ cw[2] ^ cw[3] ^ cw[6]) : 1'b0;
      syn[3] = (rt == RATE_4_8) ? (^cw) : 1'b0;
      r.codeword_bits = '0;
      if (syn == '0) begin
         r.word_out = {4'h0, cw[3:0]};
         r.status   = STATUS_OK;
         return r;
      end
      // 4/5, 4/6 fix just a lone parity check, 4/7 any syndrome; 4/8 needs overall check
      case (rt)
         RATE_4_8: fixable = syn[3];
         RATE_4_7: fixable = 1'b1;
         default:  fixable = (syn != 4'd3);
      endcase
      if (!fixable) begin
         r.word_out = '0;
         r.status   = STATUS_UNCORRECT;
         return r;
      end
      case (syn[2:0])
         3'd0: flip_pos = 7;
         3'd1: flip_pos = 4;
         3'd2: flip_pos = 5;
         3'd3: flip_pos = 0;
         3'd4: flip_pos = 6;
         3'd5: flip_pos = 1;
         3'd6: flip_pos = 2;
         default: flip_pos = 3;
      endcase
      cw[flip_pos] = ~cw[flip_pos];
      r.word_out = {4'h0, cw[3:0]};
      r.status   = STATUS_CORRECTED;
      return r;
   endfunction

   // Offer one item and hold it until the codec takes it
   task automatic offer_item(op_type op, rate_type rt, word_type w, codec_result_type want);
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.code_rate <= rt;
      req_bus.data_word <= w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(want);
   endtask

   // Keep the current burst going, or drop valid for a gap and start a new burst
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
      end
   endtask

   // Stimulus: reset, directed table, random items, drain
   initial begin
      directed_row_type row;
      codec_result_type want;
      op_type           op;
      rate_type         rt;
      word_type         w;
      int               width;
      int               kind;
      int               flips;
      int               pos_a;
      int               pos_b;

      directed_rows = '{
         '{OP_ENCODE, RATE_4_5, 8'h00, 1'b1, 8'h00, 4'd5, STATUS_OK},
         '{OP_ENCODE, RATE_4_8, 8'h0F, 1'b1, 8'hFF, 4'd8, STATUS_OK},
         '{OP_ENCODE, RATE_4_8, 8'hF0, 1'b1, 8'h00, 4'd8, STATUS_OK},
         '{OP_ENCODE, RATE_4_5, 8'hFF, 1'b1, 8'h1F, 4'd5, STATUS_OK},
         '{OP_ENCODE, RATE_4_6, 8'h5A, 1'b0, 8'h00, 4'd0, STATUS_OK},
         '{OP_ENCODE, RATE_4_7, 8'h0B, 1'b0, 8'h00, 4'd0, STATUS_OK},
         '{OP_DECODE, RATE_4_8, 8'h00, 1'b1, 8'h00, 4'd0, STATUS_OK},
         '{OP_DECODE, RATE_4_8, 8'hFF, 1'b1, 8'h0F, 4'd0, STATUS_OK},
         // parity-only repair at the short rates
         '{OP_DECODE, RATE_4_5, 8'h10, 1'b1, 8'h00, 4'd0, STATUS_CORRECTED},
         '{OP_DECODE, RATE_4_6, 8'h20, 1'b1, 8'h00, 4'd0, STATUS_CORRECTED},
         // both checks fire at 4/6: no single parity bit explains it
         '{OP_DECODE, RATE_4_6, 8'h30, 1'b1, 8'h00, 4'd0, STATUS_UNCORRECT},
         // double error at 4/8
         '{OP_DECODE, RATE_4_8, 8'h03, 1'b1, 8'h00, 4'd0, STATUS_UNCORRECT},
         '{OP_DECODE, RATE_4_8, 8'h01, 1'b1, 8'h00, 4'd0, STATUS_CORRECTED},
         '{OP_DECODE, RATE_4_8, 8'h80, 1'b1, 8'h00, 4'd0, STATUS_CORRECTED},
         '{OP_DECODE, RATE_4_7, 8'h08, 1'b1, 8'h00, 4'd0, STATUS_CORRECTED},
         // bits above the codeword width are ignored
         '{OP_DECODE, RATE_4_5, 8'hE0, 1'b1, 8'h00, 4'd0, STATUS_OK},
         '{OP_DECODE, RATE_4_7, 8'hFF, 1'b1, 8'h0F, 4'd0, STATUS_OK},
         '{OP_DECODE, RATE_4_8, 8'hC7, 1'b0, 8'h00, 4'd0, STATUS_OK}
      };

      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_ENCODE;
      req_bus.code_rate <= RATE_4_5;
      req_bus.data_word <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.known)
            want = '{row.exp_word, row.exp_bits, row.exp_status};
         else
            want = hamming_result(row.op, row.rate, row.word);
         offer_item(row.op, row.rate, row.word, want);
         pace_sender();
      end

      // Random items: encodes, valid codewords with zero to two flipped bits, and random words
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         rt    = rate_type'($urandom_range(0, 3));
         width = 5 + int'(rt);
         kind  = $urandom_range(0, 99);
         if (kind < 35) begin
            op = OP_ENCODE;
            w  = word_type'($urandom_range(0, 255));
         end else if (kind < 82) begin
            op    = OP_DECODE;
            w     = hamming_encode(4'($urandom_range(0, 15)), rt);
            flips = $urandom_range(0, 2);
            pos_a = $urandom_range(0, width - 1);
            pos_b = (pos_a + 1 + $urandom_range(0, width - 2)) % width;
            if (flips >= 1) w[pos_a] = ~w[pos_a];
            if (flips == 2) w[pos_b] = ~w[pos_b];
            // random junk above the codeword
            if ($urandom_range(0, 1) == 1)
               w = w | word_type'($urandom_range(0, 255) << width);
         end else begin
            op = OP_DECODE;
            w  = word_type'($urandom_range(0, 255));
         end
         offer_item(op, rt, w, hamming_result(op, rt, w));
         pace_sender();
      end

      // Drain the results, then let the pipeline settle
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Receiver: switch between open, coin-flip, choked and periodic stall patterns
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 3));
         rx_left <= $urandom_range(16, 160);
      end else begin
         rx_left <= rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:     rsp_bus.ready <= 1'b1;
         RX_COIN:     rsp_bus.ready <= 1'($urandom_range(0, 1));
         RX_CHOKED:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_bus.ready <= (cycle_count % 5) < 2;
      endcase
   end

   task automatic report_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each taken result against the oldest expectation
   always @(posedge clock) begin
      codec_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h", $time,
                     rsp_bus.word_out, rsp_bus.codeword_bits, rsp_bus.status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            report_field("word_out", want.word_out, rsp_bus.word_out);
            report_field("codeword_bits", want.codeword_bits, rsp_bus.codeword_bits);
            report_field("status", want.status, rsp_bus.status);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule

`default_nettype wire

>>> filelist.f
design/hnc_pkg.sv
design/hnc_if.sv
design/hamming_nibble_codec_core.sv
tb/sv/tb.sv
